[hdl/tppg_pkg.sv]
`timescale 1ns / 1ps

package tppg_pkg;

  // Coordinate width default.
  localparam int COORD_BITS = 12;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_SELECT = 2'd3;

  // Pixel format codes. Codes above BGR32 pack as BGR32.
  localparam logic [2:0] FMT_RGB332 = 3'd0;
  localparam logic [2:0] FMT_RGB555 = 3'd1;
  localparam logic [2:0] FMT_RGB565 = 3'd2;
  localparam logic [2:0] FMT_BGR24  = 3'd3;
  localparam logic [2:0] FMT_BGR32  = 3'd4;

  // Pattern codes.
  localparam logic PAT_GRADIENT = 1'b0;
  localparam logic PAT_CELLS    = 1'b1;

  // Register reset values.
  localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [2:0]  RST_PIXEL_FORMAT = FMT_RGB565;
  localparam logic        RST_PATTERN      = PAT_GRADIENT;

  // Pattern constants.
  localparam logic [7:0] GRAD_MAX  = 8'hFF;
  localparam logic [7:0] CHECK_HI  = 8'hE0;
  localparam logic [7:0] CHECK_LO  = 8'h20;
  localparam int         CELL_DIV_X = 31;
  localparam int         CELL_DIV_Y = 23;
  localparam logic [7:0] MIX_R     = 8'd37;
  localparam logic [7:0] MIX_G     = 8'd67;
  localparam logic [7:0] MIX_B     = 8'd97;

  // Byte counts per format.
  localparam logic [2:0] BYTES_1 = 3'd1;
  localparam logic [2:0] BYTES_2 = 3'd2;
  localparam logic [2:0] BYTES_3 = 3'd3;
  localparam logic [2:0] BYTES_4 = 3'd4;

endpackage

[hdl/test_pattern_pixel_generator.sv]
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// -------   -------------------------   --------------------------------------
// in        in_valid_i / in_ready_o     pixel_x_i, pixel_y_i
// out       out_valid_o / out_ready_i   pixel_word_o, byte_count_o
// cfg       cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One word is accepted per cycle unless a stall holds the pipeline; each result is registered in the output stage.
// The gradient divisions run as a pipelined restoring divider, one or two quotient bits per
// stage over five stages, and the coarse cell uses a reciprocal multiply in the first stage.
// A stage loads whenever it is empty or the stage after it moves, so stalls hold every word
// in place and bubbles close up. Reset clears the pipeline valid bits and loads the register
// defaults; cfg_ready_o is always high.

module test_pattern_pixel_generator #(
  parameter int COORD_BITS = tppg_pkg::COORD_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [COORD_BITS-1:0]            pixel_x_i,
  input  logic [COORD_BITS-1:0]            pixel_y_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [31:0]                      pixel_word_o,
  output logic [2:0]                       byte_count_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tppg_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tppg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // Dividend is coord*255; the divisor shifted by 8 needs 21 bits.
  localparam int NW = COORD_BITS + 8;
  localparam int CW = (NW > 21) ? NW : 21;
  // Reciprocal multiply: exact for every coordinate with this shift.
  localparam int SH = COORD_BITS + 5;
  localparam int MB = COORD_BITS + 1;
  localparam int PW = COORD_BITS + MB;
  localparam logic [MB-1:0] RECIP_X =
    MB'(((1 << SH) + tppg_pkg::CELL_DIV_X - 1) / tppg_pkg::CELL_DIV_X);
  localparam logic [MB-1:0] RECIP_Y =
    MB'(((1 << SH) + tppg_pkg::CELL_DIV_Y - 1) / tppg_pkg::CELL_DIV_Y);
  localparam int NSTG = 6;

  // Configuration registers.
  logic [12:0] cfg_width_q, cfg_height_q;
  logic [2:0]  cfg_format_q;
  logic        cfg_pattern_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q   <= tppg_pkg::RST_FRAME_WIDTH;
      cfg_height_q  <= tppg_pkg::RST_FRAME_HEIGHT;
      cfg_format_q  <= tppg_pkg::RST_PIXEL_FORMAT;
      cfg_pattern_q <= tppg_pkg::RST_PATTERN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tppg_pkg::REG_FRAME_WIDTH:    cfg_width_q   <= cfg_data_i[12:0];
        tppg_pkg::REG_FRAME_HEIGHT:   cfg_height_q  <= cfg_data_i[12:0];
        tppg_pkg::REG_PIXEL_FORMAT:   cfg_format_q  <= cfg_data_i[2:0];
        tppg_pkg::REG_PATTERN_SELECT: cfg_pattern_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Divisors; configuration must only change while the pipeline is empty (not enforced here).
  logic [12:0] div_r, div_g;
  logic        zero_r, zero_g;
  assign div_r  = cfg_width_q - 13'd1;
  assign div_g  = cfg_height_q - 13'd1;
  assign zero_r = (cfg_width_q[12:1] == '0);
  assign zero_g = (cfg_height_q[12:1] == '0);

  // Restoring division steps for quotient bits hi down to lo.
  function automatic logic [CW+7:0] div_steps(input logic [CW-1:0] rem,
                                               input logic [7:0] quo,
                                               input logic [12:0] dv,
                                               input int hi, input int lo);
    logic [CW-1:0] r;
    logic [7:0]    q;
    logic [CW-1:0] sub;
    r = rem;
    q = quo;
    for (int i = 7; i >= 0; i--) begin
      if (i <= hi && i >= lo) begin
        sub = CW'(dv) << i;
        if (r >= sub) begin
          r    = r - sub;
          q[i] = 1'b1;
        end
      end
    end
    return {r, q};
  endfunction

  // Pipeline handshake.
  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !valid_q[NSTG-1] || out_ready_i;
    for (int s = NSTG - 2; s >= 0; s--) begin
      rdy[s] = !valid_q[s] || rdy[s+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  // Stage 0: coordinates, dividends and reciprocal products.
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [PW-1:0]         mx_q, my_q;
  logic [CW-1:0]         remr_q [0:4];
  logic [CW-1:0]         remg_q [0:4];
  // Stages 1 to 4.
  logic [7:0]            quor_q [1:4];
  logic [7:0]            quog_q [1:4];
  logic                  satr_q [1:4];
  logic                  satg_q [1:4];
  logic [23:0]           rgb1_q [1:4];
  logic                  chk_q  [1:4];

  logic [CW-1:0] remr_d [1:4];
  logic [CW-1:0] remg_d [1:4];
  logic [7:0]    quor_d [1:4];
  logic [7:0]    quog_d [1:4];
  logic          satr_d, satg_d;
  logic [7:0]    cell8, x8, y8;
  logic [23:0]   rgb1_d;

  always_comb begin
    // Quotient of 256 or more saturates.
    satr_d = (remr_q[0] >= (CW'(div_r) << 8));
    satg_d = (remg_q[0] >= (CW'(div_g) << 8));
    {remr_d[1], quor_d[1]} = div_steps(remr_q[0], 8'h00, div_r, 7, 7);
    {remg_d[1], quog_d[1]} = div_steps(remg_q[0], 8'h00, div_g, 7, 7);
    for (int s = 2; s <= 4; s++) begin
      {remr_d[s], quor_d[s]} = div_steps(remr_q[s-1], quor_q[s-1], div_r,
                                         10 - 2 * s, 9 - 2 * s);
      {remg_d[s], quog_d[s]} = div_steps(remg_q[s-1], quog_q[s-1], div_g,
                                         10 - 2 * s, 9 - 2 * s);
    end
    // Only the low byte of the coarse cell reaches the colors.
    cell8  = 8'(mx_q[PW-1:SH]) + 8'(my_q[PW-1:SH]);
    x8     = x_q[7:0];
    y8     = y_q[7:0];
    rgb1_d = {8'(cell8 * tppg_pkg::MIX_R) + x8,
              8'(cell8 * tppg_pkg::MIX_G) + y8,
              8'(cell8 * tppg_pkg::MIX_B) + x8 + y8};
  end

  // Output stage: last quotient bit, color select and packing.
  logic [7:0]    quor_f, quog_f;
  logic [7:0]    red, grn, blu;
  logic [31:0]   word_d;
  logic [2:0]    count_d;

  always_comb begin
    quor_f = 8'(div_steps(remr_q[4], quor_q[4], div_r, 0, 0));
    quog_f = 8'(div_steps(remg_q[4], quog_q[4], div_g, 0, 0));
    if (cfg_pattern_q == tppg_pkg::PAT_CELLS) begin
      {red, grn, blu} = rgb1_q[4];
    end else begin
      red = zero_r ? 8'h00 : (satr_q[4] ? tppg_pkg::GRAD_MAX : quor_f);
      grn = zero_g ? 8'h00 : (satg_q[4] ? tppg_pkg::GRAD_MAX : quog_f);
      blu = chk_q[4] ? tppg_pkg::CHECK_HI : tppg_pkg::CHECK_LO;
    end
    unique case (cfg_format_q)
      tppg_pkg::FMT_RGB332: begin
        word_d  = {24'h0, red[7:5], grn[7:5], blu[7:6]};
        count_d = tppg_pkg::BYTES_1;
      end
      tppg_pkg::FMT_RGB555: begin
        word_d  = {17'h0, red[7:3], grn[7:3], blu[7:3]};
        count_d = tppg_pkg::BYTES_2;
      end
      tppg_pkg::FMT_RGB565: begin
        word_d  = {16'h0, red[7:3], grn[7:2], blu[7:3]};
        count_d = tppg_pkg::BYTES_2;
      end
      tppg_pkg::FMT_BGR24: begin
        word_d  = {8'h0, red, grn, blu};
        count_d = tppg_pkg::BYTES_3;
      end
      default: begin
        word_d  = {8'h0, red, grn, blu};
        count_d = tppg_pkg::BYTES_4;
      end
    endcase
  end

  logic [31:0] word_q;
  logic [2:0]  count_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      x_q       <= pixel_x_i;
      y_q       <= pixel_y_i;
      mx_q      <= PW'(pixel_x_i) * PW'(RECIP_X);
      my_q      <= PW'(pixel_y_i) * PW'(RECIP_Y);
      remr_q[0] <= CW'({pixel_x_i, 8'h00} - NW'(pixel_x_i));
      remg_q[0] <= CW'({pixel_y_i, 8'h00} - NW'(pixel_y_i));
    end
    if (rdy[1] && valid_q[0]) begin
      remr_q[1] <= remr_d[1];
      remg_q[1] <= remg_d[1];
      quor_q[1] <= quor_d[1];
      quog_q[1] <= quog_d[1];
      satr_q[1] <= satr_d;
      satg_q[1] <= satg_d;
      rgb1_q[1] <= rgb1_d;
      chk_q[1]  <= x_q[4] ^ y_q[4];
    end
    for (int s = 2; s <= 4; s++) begin
      if (rdy[s] && valid_q[s-1]) begin
        remr_q[s] <= remr_d[s];
        remg_q[s] <= remg_d[s];
        quor_q[s] <= quor_d[s];
        quog_q[s] <= quog_d[s];
        satr_q[s] <= satr_q[s-1];
        satg_q[s] <= satg_q[s-1];
        rgb1_q[s] <= rgb1_q[s-1];
        chk_q[s]  <= chk_q[s-1];
      end
    end
    if (rdy[NSTG-1] && valid_q[NSTG-2]) begin
      word_q  <= word_d;
      count_q <= count_d;
    end
  end

  assign pixel_word_o = word_q;
  assign byte_count_o = count_q;

  // An accepted word always lands in the first stage.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted word missing from first stage");

  // A stalled output stage keeps its predecessor stalled too.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && valid_q[NSTG-2] |-> !rdy[NSTG-2])
    else $error("stage advanced into a stalled output");

  // In the gradient pattern with BGR24 packing the blue byte is one of the two checker values.
  a_checker_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg_pattern_q == tppg_pkg::PAT_GRADIENT && byte_count_o == tppg_pkg::BYTES_3
    |-> pixel_word_o[7:0] == tppg_pkg::CHECK_HI || pixel_word_o[7:0] == tppg_pkg::CHECK_LO)
    else $error("checker blue byte out of range");

  // A one-byte word leaves the upper bytes clear.
  a_upper_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o == tppg_pkg::BYTES_1 |-> pixel_word_o[31:8] == '0)
    else $error("upper bytes set for a one-byte pixel");

endmodule

[dv/tppg_checker.sv]
`timescale 1ns / 1ps

module tppg_checker #(
  parameter int COORD_W = tppg_pkg::COORD_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [COORD_W-1:0]               pixel_x_i,
  input  logic [COORD_W-1:0]               pixel_y_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [31:0]                      pixel_word_i,
  input  logic [2:0]                       byte_count_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [tppg_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tppg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                      pending_o,
  output int unsigned                      checked_o,
  output int unsigned                      mismatches_o
);

  localparam int PRINT_LIMIT = 50;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
  } pixel_t;

  pixel_t expected_pixels[$];

  logic [12:0] span_x;
  logic [12:0] span_y;
  logic [2:0]  fmt;
  logic        pattern;

  int unsigned checked_count  = 0;
  int unsigned mismatch_count = 0;

  assign checked_o    = checked_count;
  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // A frame of size 0 or 1 has a flat gradient; positions past the edge clip at full scale.
  function automatic int unsigned ramp_level(input int unsigned pos, input int unsigned span);
    int unsigned level;
    if (span <= 1) return 0;
    level = pos * 255 / (span - 1);
    return (level > 255) ? 255 : level;
  endfunction

  function automatic pixel_t predict_pixel(input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y);
    int unsigned r, g, b, coarse;
    pixel_t p;
    if (pattern == tppg_pkg::PAT_GRADIENT) begin
      r = ramp_level(x, span_x);
      g = ramp_level(y, span_y);
      b = (x[4] ^ y[4]) ? tppg_pkg::CHECK_HI : tppg_pkg::CHECK_LO;
    end else begin
      coarse = x / tppg_pkg::CELL_DIV_X + y / tppg_pkg::CELL_DIV_Y;
      r = (coarse * tppg_pkg::MIX_R + x) & 8'hFF;
      g = (coarse * tppg_pkg::MIX_G + y) & 8'hFF;
      b = (coarse * tppg_pkg::MIX_B + x + y) & 8'hFF;
    end
    case (fmt)
      tppg_pkg::FMT_RGB332: begin
        p.word  = (r & 8'hE0) | ((g >> 3) & 8'h1C) | (b >> 6);
        p.count = tppg_pkg::BYTES_1;
      end
      tppg_pkg::FMT_RGB555: begin
        p.word  = ((r >> 3) << 10) | ((g >> 3) << 5) | (b >> 3);
        p.count = tppg_pkg::BYTES_2;
      end
      tppg_pkg::FMT_RGB565: begin
        p.word  = ((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3);
        p.count = tppg_pkg::BYTES_2;
      end
      tppg_pkg::FMT_BGR24: begin
        p.word  = b | (g << 8) | (r << 16);
        p.count = tppg_pkg::BYTES_3;
      end
      // The spare codes pack like BGR32.
      default: begin
        p.word  = b | (g << 8) | (r << 16);
        p.count = tppg_pkg::BYTES_4;
      end
    endcase
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_t want;
    if (!rst_ni) begin
      span_x  = tppg_pkg::RST_FRAME_WIDTH;
      span_y  = tppg_pkg::RST_FRAME_HEIGHT;
      fmt     = tppg_pkg::RST_PIXEL_FORMAT;
      pattern = tppg_pkg::RST_PATTERN;
      expected_pixels.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          tppg_pkg::REG_FRAME_WIDTH:    span_x  = cfg_data_i;
          tppg_pkg::REG_FRAME_HEIGHT:   span_y  = cfg_data_i;
          tppg_pkg::REG_PIXEL_FORMAT:   fmt     = cfg_data_i[2:0];
          tppg_pkg::REG_PATTERN_SELECT: pattern = cfg_data_i[0];
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_pixels.push_back(predict_pixel(pixel_x_i, pixel_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("word 0x%08h arrived with nothing pending",
                                    pixel_word_i));
        end else begin
          want = expected_pixels.pop_front();
          checked_count++;
          if (pixel_word_i !== want.word) begin
            report_mismatch($sformatf("pixel_word 0x%08h, expected 0x%08h",
                                      pixel_word_i, want.word));
          end
          if (byte_count_i !== want.count) begin
            report_mismatch($sformatf("byte_count %0d, expected %0d",
                                      byte_count_i, want.count));
          end
        end
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_BITS      = tppg_pkg::COORD_BITS;
  localparam int CFG_INDEX_W     = tppg_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W      = tppg_pkg::CFG_DATA_W;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_PHASE      = 2;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 20;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int COORD_MAX       = (1 << COORD_BITS) - 1;

  // Format codes with no packing of their own.
  localparam logic [2:0] FMT_SPARE_LO = 3'd5;
  localparam logic [2:0] FMT_SPARE_HI = 3'd7;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   in_valid   = 1'b0;
  logic [COORD_BITS-1:0]  pixel_x    = '0;
  logic [COORD_BITS-1:0]  pixel_y    = '0;
  logic                   out_ready  = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   hold_phase = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [31:0] pixel_word;
  logic [2:0]  byte_count;
  logic        cfg_ready;

  int unsigned pixels_pending;
  int unsigned pixels_checked;
  int unsigned mismatches;
  int unsigned cycle_count      = 0;
  int unsigned pixels_sent      = 0;
  int unsigned settings_applied = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  test_pattern_pixel_generator #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .pixel_x_i   (pixel_x),
    .pixel_y_i   (pixel_y),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pixel_word_o(pixel_word),
    .byte_count_o(byte_count),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tppg_checker #(
    .COORD_W(COORD_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .pixel_x_i   (pixel_x),
    .pixel_y_i   (pixel_y),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .pixel_word_i(pixel_word),
    .byte_count_i(byte_count),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pixels_pending),
    .checked_o   (pixels_checked),
    .mismatches_o(mismatches)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] frame_span();
    case ($urandom_range(0, 7))
      0:       return CFG_DATA_W'($urandom_range(0, 2));
      1:       return 13'd4096;
      2:       return 13'h1FFF;
      3:       return CFG_DATA_W'($urandom_range(4097, 8191));
      4, 5:    return CFG_DATA_W'($urandom_range(2, 64));
      default: return CFG_DATA_W'($urandom_range(2, 4096));
    endcase
  endfunction

  // Coordinates inside the frame, on and just past its edge, or anywhere.
  function automatic logic [COORD_BITS-1:0] coord_for(input int unsigned span);
    int unsigned lim, v;
    lim = (span == 0) ? 1 : ((span > COORD_MAX + 1) ? COORD_MAX + 1 : span);
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, COORD_MAX);
      1:       v = $urandom_range(0, lim - 1);
      2:       v = lim - 1 + $urandom_range(0, 2);
      default: v = $urandom_range(0, 1) ? COORD_MAX : 0;
    endcase
    return COORD_BITS'((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // Called at a clock edge; returns at the edge where the word is taken.
  task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    do @(posedge clk_i); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic pause_random();
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pixels_pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Narrow registers get random upper data bits, which the block must ignore.
  task automatic set_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                            input logic [2:0] f, input logic p);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    write_reg(tppg_pkg::REG_FRAME_WIDTH, w);
    write_reg(tppg_pkg::REG_FRAME_HEIGHT, h);
    write_reg(tppg_pkg::REG_PIXEL_FORMAT, {noise[CFG_DATA_W-1:3], f});
    noise = CFG_DATA_W'($urandom);
    write_reg(tppg_pkg::REG_PATTERN_SELECT, {noise[CFG_DATA_W-1:1], p});
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic probe_corners();
    send_pixel('0, '0);
    send_pixel(COORD_BITS'(639), COORD_BITS'(479));
    // Just outside the default frame, where both gradients still read full scale.
    send_pixel(COORD_BITS'(640), COORD_BITS'(480));
    send_pixel(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX));
    // Straddles a checkerboard cell boundary.
    send_pixel(COORD_BITS'(16), COORD_BITS'(15));
    send_pixel(12'hAAA, 12'h555);
    drain_results();
  endtask

  task automatic run_phase(input bit hold, input bit sender_idles);
    logic [CFG_DATA_W-1:0] w, h;
    logic [2:0]            f;
    logic                  p;
    w = frame_span();
    h = frame_span();
    f = 3'($urandom_range(0, 7));
    p = 1'($urandom_range(0, 1));
    set_config(w, h, f, p);
    if (hold) hold_phase <= 1'b1;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (sender_idles && !hold) pause_random();
      send_pixel(coord_for(w), coord_for(h));
    end
    if (hold) hold_phase <= 1'b0;
    drain_results();
  endtask

  // The receiver stalls on its own; once per hold phase it stops taking words for a long
  // stretch so the pipeline fills and pushes back on the sender.
  initial begin : result_sink
    int unsigned stall;
    bit held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_phase && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        if (!hold_phase) held = 1'b0;
        stall = idle_gap();
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults first, then flat gradients, oversized frames and spare formats.
    probe_corners();
    set_config(13'd0, 13'd1, tppg_pkg::FMT_RGB332, tppg_pkg::PAT_GRADIENT);
    probe_corners();
    set_config(13'h1FFF, 13'd4097, FMT_SPARE_LO, tppg_pkg::PAT_CELLS);
    probe_corners();
    set_config(13'd1, 13'd0, FMT_SPARE_HI, tppg_pkg::PAT_GRADIENT);
    probe_corners();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      run_phase(phase == HOLD_PHASE, $urandom_range(0, 3) != 0);
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d pixels under %0d register settings, one with a %0d-cycle hold-off;",
             pixels_sent, settings_applied + 1, HOLD_CYCLES);
    $display("compared %0d results, %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
